/* design/gpc_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gpc_pkg
// Shared types, request codes and register word codes for the GPIO port
// controller.
// ---------------------------------------------------------------------------
package gpc_pkg;

    localparam int GPC_NUM_PORTS = 8;
    localparam int PORT_W        = 4;   // port index as decoded from the address
    localparam int WORD_W        = 4;   // register word within a group
    localparam int DEB_W         = 7;

    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_SAMPLE = 2'd2;

    // Word codes inside a pin register group.
    localparam logic [WORD_W-1:0] W_FUNC0     = 4'd0;
    localparam logic [WORD_W-1:0] W_FUNC1     = 4'd1;
    localparam logic [WORD_W-1:0] W_FUNC2     = 4'd2;
    localparam logic [WORD_W-1:0] W_FUNC_LAST = 4'd3;
    localparam logic [WORD_W-1:0] W_DATA      = 4'd4;
    localparam logic [WORD_W-1:0] W_DRV0      = 4'd5;
    localparam logic [WORD_W-1:0] W_DRV1      = 4'd6;
    localparam logic [WORD_W-1:0] W_PULL0     = 4'd7;
    localparam logic [WORD_W-1:0] W_PULL1     = 4'd8;

    // Word codes inside an interrupt group.
    localparam logic [WORD_W-1:0] W_TRIG0     = 4'd0;
    localparam logic [WORD_W-1:0] W_TRIG1     = 4'd1;
    localparam logic [WORD_W-1:0] W_TRIG2     = 4'd2;
    localparam logic [WORD_W-1:0] W_TRIG_LAST = 4'd3;
    localparam logic [WORD_W-1:0] W_IRQ_EN    = 4'd4;
    localparam logic [WORD_W-1:0] W_IRQ_PEND  = 4'd5;
    localparam logic [WORD_W-1:0] W_DEBOUNCE  = 4'd6;
    localparam logic [WORD_W-1:0] W_INT_HOLE  = 4'd7;

    // Trigger mode codes.
    localparam logic [3:0] TRIG_RISE  = 4'd0;
    localparam logic [3:0] TRIG_FALL  = 4'd1;
    localparam logic [3:0] TRIG_HIGH  = 4'd2;
    localparam logic [3:0] TRIG_LOW   = 4'd3;
    localparam logic [3:0] TRIG_BOTH  = 4'd4;

    localparam logic [3:0]  FUNC_OUTPUT = 4'd1;
    localparam logic [31:0] FUNC_RESET  = 32'h7777_7777;

    // Reciprocal of the port stride in words (9): floor(w * 57 / 512) == w / 9
    // for every word index below 128.
    localparam logic [5:0] STRIDE_RECIP = 6'd57;
    localparam int         RECIP_SHIFT  = 9;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [9:0]  addr;
        logic [31:0] wdata;
        logic [2:0]  sample_port;
        logic [31:0] pin_levels;
    } t_req;

    typedef struct packed {
        logic [31:0] rdata;
        logic        addr_error;
        logic        irq;
    } t_rsp;

    typedef struct packed {
        logic              ok;
        logic              is_int;
        logic [PORT_W-1:0] port;
        logic [WORD_W-1:0] word;
    } t_dec;

    typedef struct packed {
        logic              bus_sel;
        logic              wr;
        logic              is_int;
        logic [WORD_W-1:0] word;
        logic [31:0]       wdata;
        logic              smp;
        logic [31:0]       levels;
    } t_lane_ctl;

    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
    } t_lane_stat;

endpackage
`default_nettype wire

/* design/gpc_decode.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gpc_decode
// Address decoder: splits a byte offset into group kind, port and word, and
// flags offsets that map to no register.
// ---------------------------------------------------------------------------
module gpc_decode #(
    parameter int NUM_PORTS = gpc_pkg::GPC_NUM_PORTS
) (
    input  wire logic [9:0]    i_addr,
    output gpc_pkg::t_dec      o_dec
);
    import gpc_pkg::*;

    localparam logic [PORT_W-1:0] NP = PORT_W'(NUM_PORTS);

    logic [6:0]        word_idx;
    logic [12:0]       recip_prod;
    logic [PORT_W-1:0] pin_port;
    logic [6:0]        port_x9;
    logic [6:0]        pin_word;
    logic [PORT_W-1:0] int_port;
    logic [2:0]        int_word;

    always_comb begin
        word_idx   = i_addr[8:2];
        // Divide the word index by the 9-word stride of a pin group.
        recip_prod = 13'(word_idx) * 13'(STRIDE_RECIP);
        pin_port   = recip_prod[RECIP_SHIFT +: PORT_W];
        port_x9    = {pin_port, 3'b000} + 7'(pin_port);
        pin_word   = word_idx - port_x9;

        int_port   = i_addr[8:5];
        int_word   = i_addr[4:2];

        o_dec.is_int = i_addr[9];
        if (i_addr[9]) begin
            o_dec.port = int_port;
            o_dec.word = WORD_W'(int_word);
            o_dec.ok   = (i_addr[1:0] == 2'b00) && (int_port < NP)
                         && (WORD_W'(int_word) != W_INT_HOLE);
        end else begin
            o_dec.port = pin_port;
            o_dec.word = pin_word[WORD_W-1:0];
            o_dec.ok   = (i_addr[1:0] == 2'b00) && (pin_port < NP);
        end
    end

endmodule
`default_nettype wire

/* design/gpc_port.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gpc_port
// One port lane: pin and interrupt registers, data readback, and trigger
// evaluation of all 32 pins on a pad sample.
// ---------------------------------------------------------------------------
module gpc_port (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  gpc_pkg::t_lane_ctl     i_ctl,
    output gpc_pkg::t_lane_stat    o_stat
);
    import gpc_pkg::*;

    logic [3:0][31:0] r_func;
    logic [31:0]      r_latch;
    logic [1:0][31:0] r_drive;
    logic [1:0][31:0] r_pull;
    logic [31:0]      r_last;
    logic [3:0][31:0] r_trig;
    logic [31:0]      r_irq_en;
    logic [31:0]      r_irq_pend;
    logic [DEB_W-1:0] r_deb;

    logic [31:0] n_irq_en;
    logic [31:0] n_irq_pend;
    logic [31:0] hit;
    logic [31:0] data_rd;
    logic        pin_wr;
    logic        int_wr;

    assign pin_wr = i_ctl.bus_sel && i_ctl.wr && !i_ctl.is_int;
    assign int_wr = i_ctl.bus_sel && i_ctl.wr &&  i_ctl.is_int;

    // Per-pin data readback and trigger evaluation.
    always_comb begin
        for (int k = 0; k < 32; k++) begin
            data_rd[k] = (r_func[k / 8][(k % 8) * 4 +: 4] == FUNC_OUTPUT)
                         ? r_latch[k] : r_last[k];
            case (r_trig[k / 8][(k % 8) * 4 +: 4])
                TRIG_RISE: hit[k] = !r_last[k] &&  i_ctl.levels[k];
                TRIG_FALL: hit[k] =  r_last[k] && !i_ctl.levels[k];
                TRIG_HIGH: hit[k] =  i_ctl.levels[k];
                TRIG_LOW:  hit[k] = !i_ctl.levels[k];
                TRIG_BOTH: hit[k] =  r_last[k] != i_ctl.levels[k];
                default:   hit[k] = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_irq_en   = r_irq_en;
        n_irq_pend = r_irq_pend;
        if (i_ctl.smp) begin
            n_irq_pend = r_irq_pend | hit;
        end
        if (int_wr && i_ctl.word == W_IRQ_EN) begin
            n_irq_en = i_ctl.wdata;
        end
        if (int_wr && i_ctl.word == W_IRQ_PEND) begin
            n_irq_pend = r_irq_pend & ~i_ctl.wdata;
        end
    end

    // Interrupt state after this transaction has been applied.
    assign o_stat.irq = |(n_irq_pend & n_irq_en);

    always_comb begin
        o_stat.rdata = '0;
        if (i_ctl.bus_sel) begin
            if (i_ctl.is_int) begin
                case (i_ctl.word)
                    W_TRIG0, W_TRIG1, W_TRIG2, W_TRIG_LAST:
                        o_stat.rdata = r_trig[i_ctl.word[1:0]];
                    W_IRQ_EN:   o_stat.rdata = r_irq_en;
                    W_IRQ_PEND: o_stat.rdata = r_irq_pend;
                    W_DEBOUNCE: o_stat.rdata = 32'(r_deb);
                    default:    o_stat.rdata = '0;
                endcase
            end else begin
                case (i_ctl.word)
                    W_FUNC0, W_FUNC1, W_FUNC2, W_FUNC_LAST:
                        o_stat.rdata = r_func[i_ctl.word[1:0]];
                    W_DATA:  o_stat.rdata = data_rd;
                    W_DRV0:  o_stat.rdata = r_drive[0];
                    W_DRV1:  o_stat.rdata = r_drive[1];
                    W_PULL0: o_stat.rdata = r_pull[0];
                    W_PULL1: o_stat.rdata = r_pull[1];
                    default: o_stat.rdata = '0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func     <= {4{FUNC_RESET}};
            r_latch    <= '0;
            r_drive    <= '0;
            r_pull     <= '0;
            r_last     <= '0;
            r_trig     <= '0;
            r_irq_en   <= '0;
            r_irq_pend <= '0;
            r_deb      <= '0;
        end else begin
            r_irq_en   <= n_irq_en;
            r_irq_pend <= n_irq_pend;
            if (i_ctl.smp) begin
                r_last <= i_ctl.levels;
            end
            if (pin_wr) begin
                case (i_ctl.word)
                    W_FUNC0, W_FUNC1, W_FUNC2, W_FUNC_LAST:
                        r_func[i_ctl.word[1:0]] <= i_ctl.wdata;
                    W_DATA:  r_latch    <= i_ctl.wdata;
                    W_DRV0:  r_drive[0] <= i_ctl.wdata;
                    W_DRV1:  r_drive[1] <= i_ctl.wdata;
                    W_PULL0: r_pull[0]  <= i_ctl.wdata;
                    W_PULL1: r_pull[1]  <= i_ctl.wdata;
                    default: ;
                endcase
            end
            if (int_wr) begin
                case (i_ctl.word)
                    W_TRIG0, W_TRIG1, W_TRIG2, W_TRIG_LAST:
                        r_trig[i_ctl.word[1:0]] <= i_ctl.wdata;
                    W_DEBOUNCE: r_deb <= i_ctl.wdata[DEB_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

/* design/gpio_port_controller_core.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gpio_port_controller_core
// Bus-mapped GPIO bank with per-port pin registers and external interrupts.
// ---------------------------------------------------------------------------
// Every request (bus read, bus write or pad sample) yields one response.
// The block takes one transaction per clock cycle while the output is not
// stalled; a request lands in an input register, the address decode,
// register update and trigger logic of all 32 pins run on that registered
// request, and the response is held in an output register, which drives
// o_out_valid. A stalled output holds at most one more request in the input
// register before o_in_ready drops.
// All port lanes are evaluated in parallel and irq reflects the state after
// the request has been applied.
// ---------------------------------------------------------------------------
module gpio_port_controller_core #(
    parameter int NUM_PORTS = gpc_pkg::GPC_NUM_PORTS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  gpc_pkg::t_req   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output gpc_pkg::t_rsp   o_out_data
);
    import gpc_pkg::*;

    logic       r_in_valid;
    t_req       r_in;
    logic       r_out_valid;
    t_rsp       r_out;
    t_rsp       n_out;
    logic       advance;
    logic       is_bus;
    t_dec       dec;
    logic [31:0] rd_any;
    logic        irq_any;

    t_lane_ctl  lane_ctl  [NUM_PORTS];
    t_lane_stat lane_stat [NUM_PORTS];

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign is_bus      = (r_in.req_type == REQ_READ) || (r_in.req_type == REQ_WRITE);

    gpc_decode #(
        .NUM_PORTS (NUM_PORTS)
    ) u_decode (
        .i_addr (r_in.addr),
        .o_dec  (dec)
    );

    for (genvar g = 0; g < NUM_PORTS; g++) begin : g_lane
        always_comb begin
            lane_ctl[g].bus_sel = advance && is_bus && dec.ok && (dec.port == PORT_W'(g));
            lane_ctl[g].wr      = r_in.req_type == REQ_WRITE;
            lane_ctl[g].is_int  = dec.is_int;
            lane_ctl[g].word    = dec.word;
            lane_ctl[g].wdata   = r_in.wdata;
            lane_ctl[g].smp     = advance && (r_in.req_type == REQ_SAMPLE)
                                  && ({1'b0, r_in.sample_port} == PORT_W'(g));
            lane_ctl[g].levels  = r_in.pin_levels;
        end

        gpc_port u_port (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl[g]),
            .o_stat  (lane_stat[g])
        );
    end

    // Only the addressed lane drives nonzero read data.
    always_comb begin
        rd_any  = '0;
        irq_any = 1'b0;
        for (int p = 0; p < NUM_PORTS; p++) begin
            rd_any  = rd_any | lane_stat[p].rdata;
            irq_any = irq_any | lane_stat[p].irq;
        end
        n_out.rdata      = (r_in.req_type == REQ_READ && dec.ok) ? rd_any : '0;
        n_out.addr_error = is_bus && !dec.ok;
        n_out.irq        = irq_any;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire
